/* rtl/transfer_record_byte_parser_assert.svh */
// Assertion macros used by the checker file.
// Both sample on the rising edge of clk and are held off while rst_n is low.
`ifndef TRANSFER_RECORD_BYTE_PARSER_ASSERT_SVH
`define TRANSFER_RECORD_BYTE_PARSER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define TRBP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("trbp assertion failed");

// Consequent must hold in the cycle after the antecedent
`define TRBP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("trbp assertion failed");

`endif

/* rtl/trbp_pkg.sv */
`default_nettype none

package trbp_pkg;

  // Field tags on the result beat
  localparam logic [3:0] FC_TYPE       = 4'd0;
  localparam logic [3:0] FC_SENDER     = 4'd1;
  localparam logic [3:0] FC_AMT_FLAG   = 4'd2;
  localparam logic [3:0] FC_AMT_ASSET  = 4'd3;
  localparam logic [3:0] FC_FEE_FLAG   = 4'd4;
  localparam logic [3:0] FC_FEE_ASSET  = 4'd5;
  localparam logic [3:0] FC_TIMESTAMP  = 4'd6;
  localparam logic [3:0] FC_AMOUNT     = 4'd7;
  localparam logic [3:0] FC_FEE        = 4'd8;
  localparam logic [3:0] FC_RECIPIENT  = 4'd9;
  localparam logic [3:0] FC_ATT_LEN    = 4'd10;
  localparam logic [3:0] FC_ATTACHMENT = 4'd11;
  localparam logic [3:0] FC_IGNORED    = 4'd12;

  // Record status codes
  localparam logic [1:0] ST_BUSY       = 2'd0;
  localparam logic [1:0] ST_ACCEPTED   = 2'd1;
  localparam logic [1:0] ST_BAD_ALIAS  = 2'd2;
  localparam logic [1:0] ST_ATT_LONG   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_ALIAS_MIN = 2'd0;
  localparam logic [1:0] CFG_ALIAS_MAX = 2'd1;
  localparam logic [1:0] CFG_ATT_MAX   = 2'd2;

  // Register reset values
  localparam logic [15:0] ALIAS_MIN_RST = 16'd4;
  localparam logic [15:0] ALIAS_MAX_RST = 16'd30;
  localparam logic [15:0] ATT_MAX_RST   = 16'd140;

  // Field sizes in bytes
  localparam logic [15:0] KEY_BYTES        = 16'd32;
  localparam logic [15:0] RECIP_ADDR_BYTES = 16'd26;
  localparam logic [15:0] NUMBER_BYTES     = 16'd8;
  localparam logic [15:0] ALIAS_HDR_BYTES  = 16'd4;
  localparam logic [15:0] ATT_LEN_BYTES    = 16'd2;

  typedef struct packed {
    logic [15:0] alias_min;
    logic [15:0] alias_max;
    logic [15:0] att_max;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       sof;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]  field_code;
    logic [15:0] byte_position;
    logic [7:0]  echoed_byte;
    logic [63:0] number_value;
    logic        number_ready;
    logic [1:0]  parse_status;
  } result_t;

endpackage

`default_nettype wire

/* rtl/trbp_cfg_regs.sv */
`default_nettype none

module trbp_cfg_regs (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [15:0]    cfg_data,
  output trbp_pkg::cfg_t      cfg
);
  import trbp_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  // Writes are always taken; an index past the list is dropped
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_ALIAS_MIN: cfg_nxt.alias_min = cfg_data;
        CFG_ALIAS_MAX: cfg_nxt.alias_max = cfg_data;
        CFG_ATT_MAX:   cfg_nxt.att_max   = cfg_data;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{alias_min: ALIAS_MIN_RST, alias_max: ALIAS_MAX_RST, att_max: ATT_MAX_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* rtl/trbp_in_stage.sv */
`default_nettype none

module trbp_in_stage (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire trbp_pkg::in_beat_t  in_beat,
  input  wire logic                advance,
  output logic                     held_valid,
  output trbp_pkg::in_beat_t       held_beat
);
  import trbp_pkg::*;

  logic     vld_r;
  in_beat_t beat_r;

  // Free when empty or when the held beat moves on this cycle
  assign in_ready = !vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat_r <= in_beat;
    end
  end

  assign held_valid = vld_r;
  assign held_beat  = beat_r;

endmodule

`default_nettype wire

/* rtl/trbp_field_fsm.sv */
`default_nettype none

module trbp_field_fsm (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                advance,
  input  wire trbp_pkg::in_beat_t  beat,
  input  wire trbp_pkg::cfg_t      cfg,
  output trbp_pkg::result_t        res
);
  import trbp_pkg::*;

  // Parse phases
  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_SENDER   = 4'd1;
  localparam logic [3:0] PH_AFLAG    = 4'd2;
  localparam logic [3:0] PH_AASSET   = 4'd3;
  localparam logic [3:0] PH_FFLAG    = 4'd4;
  localparam logic [3:0] PH_FASSET   = 4'd5;
  localparam logic [3:0] PH_TS       = 4'd6;
  localparam logic [3:0] PH_AMOUNT   = 4'd7;
  localparam logic [3:0] PH_FEE      = 4'd8;
  localparam logic [3:0] PH_RECIP    = 4'd9;
  localparam logic [3:0] PH_ADDRESS  = 4'd10;
  localparam logic [3:0] PH_ALIASHDR = 4'd11;
  localparam logic [3:0] PH_ALIAS    = 4'd12;
  localparam logic [3:0] PH_ATTLEN   = 4'd13;
  localparam logic [3:0] PH_ATTACH   = 4'd14;

  logic [3:0]  phase_r, phase_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] pend_r, pend_nxt;
  logic [63:0] acc_r, acc_nxt;

  logic [15:0] cnt_inc;
  logic [63:0] acc_shift;
  logic [15:0] hdr_len;
  logic [7:0]  b;
  logic        flag_set;

  assign b         = beat.data_byte;
  assign cnt_inc   = cnt_r + 16'd1;
  assign acc_shift = {acc_r[55:0], b};
  assign hdr_len   = (cnt_r >= 16'd2) ? {pend_r[7:0], b} : pend_r;
  assign flag_set  = (b == 8'd1);

  // Per-byte tagging and next state
  always_comb begin
    res = '{field_code: FC_IGNORED, byte_position: 16'd0, echoed_byte: b,
            number_value: 64'd0, number_ready: 1'b0, parse_status: ST_BUSY};
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    pend_nxt  = pend_r;
    acc_nxt   = acc_r;

    if (beat.sof) begin
      res.field_code = FC_TYPE;
      pend_nxt  = 16'd0;
      phase_nxt = PH_SENDER;
      cnt_nxt   = 16'd0;
      acc_nxt   = 64'd0;
    end else begin
      case (phase_r)
        PH_SENDER, PH_AASSET, PH_FASSET: begin
          res.field_code    = (phase_r == PH_SENDER) ? FC_SENDER :
                              (phase_r == PH_AASSET) ? FC_AMT_ASSET : FC_FEE_ASSET;
          res.byte_position = cnt_r;
          cnt_nxt = cnt_inc;
          if (cnt_inc >= KEY_BYTES) begin
            phase_nxt = (phase_r == PH_SENDER) ? PH_AFLAG :
                        (phase_r == PH_AASSET) ? PH_FFLAG : PH_TS;
            cnt_nxt   = 16'd0;
            acc_nxt   = 64'd0;
          end
        end
        PH_AFLAG: begin
          res.field_code = FC_AMT_FLAG;
          phase_nxt = flag_set ? PH_AASSET : PH_FFLAG;
          cnt_nxt   = 16'd0;
          acc_nxt   = 64'd0;
        end
        PH_FFLAG: begin
          res.field_code = FC_FEE_FLAG;
          phase_nxt = flag_set ? PH_FASSET : PH_TS;
          cnt_nxt   = 16'd0;
          acc_nxt   = 64'd0;
        end
        PH_TS, PH_AMOUNT, PH_FEE: begin
          res.field_code    = (phase_r == PH_TS)     ? FC_TIMESTAMP :
                              (phase_r == PH_AMOUNT) ? FC_AMOUNT : FC_FEE;
          res.byte_position = cnt_r;
          res.number_value  = acc_shift;
          acc_nxt = acc_shift;
          cnt_nxt = cnt_inc;
          if (cnt_inc >= NUMBER_BYTES) begin
            res.number_ready = 1'b1;
            phase_nxt = (phase_r == PH_TS)     ? PH_AMOUNT :
                        (phase_r == PH_AMOUNT) ? PH_FEE : PH_RECIP;
            cnt_nxt   = 16'd0;
            acc_nxt   = 64'd0;
          end
        end
        PH_RECIP: begin
          // First recipient byte picks address or alias form
          res.field_code = FC_RECIPIENT;
          pend_nxt  = 16'd0;
          phase_nxt = flag_set ? PH_ADDRESS : PH_ALIASHDR;
          cnt_nxt   = 16'd1;
          acc_nxt   = 64'd0;
        end
        PH_ADDRESS: begin
          res.field_code    = FC_RECIPIENT;
          res.byte_position = cnt_r;
          cnt_nxt = cnt_inc;
          if (cnt_inc >= RECIP_ADDR_BYTES) begin
            phase_nxt = PH_ATTLEN;
            cnt_nxt   = 16'd0;
            acc_nxt   = 64'd0;
          end
        end
        PH_ALIASHDR: begin
          // Last two header bytes carry the alias length, big-endian
          res.field_code    = FC_RECIPIENT;
          res.byte_position = cnt_r;
          pend_nxt = hdr_len;
          cnt_nxt  = cnt_inc;
          if (cnt_inc >= ALIAS_HDR_BYTES) begin
            cnt_nxt = 16'd0;
            acc_nxt = 64'd0;
            if (hdr_len < cfg.alias_min || hdr_len > cfg.alias_max) begin
              res.parse_status = ST_BAD_ALIAS;
              phase_nxt = PH_IDLE;
            end else if (hdr_len == 16'd0) begin
              phase_nxt = PH_ATTLEN;
            end else begin
              phase_nxt = PH_ALIAS;
            end
          end
        end
        PH_ALIAS: begin
          // Positions run on from the header and wrap at 16 bits
          res.field_code    = FC_RECIPIENT;
          res.byte_position = cnt_r + ALIAS_HDR_BYTES;
          cnt_nxt = cnt_inc;
          if (cnt_inc >= pend_r) begin
            phase_nxt = PH_ATTLEN;
            cnt_nxt   = 16'd0;
            acc_nxt   = 64'd0;
          end
        end
        PH_ATTLEN: begin
          res.field_code    = FC_ATT_LEN;
          res.byte_position = cnt_r;
          res.number_value  = acc_shift;
          acc_nxt = acc_shift;
          cnt_nxt = cnt_inc;
          if (cnt_inc >= ATT_LEN_BYTES) begin
            res.number_ready = 1'b1;
            pend_nxt = acc_shift[15:0];
            cnt_nxt  = 16'd0;
            acc_nxt  = 64'd0;
            if (acc_shift[15:0] > cfg.att_max) begin
              res.parse_status = ST_ATT_LONG;
              phase_nxt = PH_IDLE;
            end else if (acc_shift[15:0] == 16'd0) begin
              res.parse_status = ST_ACCEPTED;
              phase_nxt = PH_IDLE;
            end else begin
              phase_nxt = PH_ATTACH;
            end
          end
        end
        PH_ATTACH: begin
          res.field_code    = FC_ATTACHMENT;
          res.byte_position = cnt_r;
          cnt_nxt = cnt_inc;
          if (cnt_inc >= pend_r) begin
            res.parse_status = ST_ACCEPTED;
            phase_nxt = PH_IDLE;
            cnt_nxt   = 16'd0;
            acc_nxt   = 64'd0;
          end
        end
        default: begin
          // Idle, or an unused code: byte ignored
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  // Parser state moves once per beat handed on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= 16'd0;
      pend_r  <= 16'd0;
      acc_r   <= 64'd0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      acc_r   <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/trbp_out_stage.sv */
`default_nettype none

module trbp_out_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire trbp_pkg::result_t  res_in,
  output logic                    has_space,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output trbp_pkg::result_t       res_out
);
  import trbp_pkg::*;

  logic    vld_r;
  result_t res_r;

  // Room when empty or when the current beat leaves this cycle
  assign has_space = !vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (has_space) begin
      vld_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = vld_r;
  assign res_out   = res_r;

endmodule

`default_nettype wire

/* rtl/transfer_record_byte_parser.sv */
// Each input beat passes the input register, then the result register; the tagging logic
// between them runs once per byte. Throughput: one byte per cycle when nothing stalls.
// Backpressure on the result side stalls the input register, which stalls in_ready.
// Reset (rst_n low, synchronous): parser idle, counters and accumulator cleared, both
// stages empty, registers back to alias 4..30 bytes and attachment limit 140 bytes.
`default_nettype none

module transfer_record_byte_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_start_of_frame,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_field_code,
  output logic [15:0]      out_byte_position,
  output logic [7:0]       out_echoed_byte,
  output logic [63:0]      out_number_value,
  output logic             out_number_ready,
  output logic [1:0]       out_parse_status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import trbp_pkg::*;

  cfg_t     cfg;
  in_beat_t in_beat;
  in_beat_t held_beat;
  logic     held_valid;
  logic     has_space;
  logic     advance;
  result_t  res_comb;
  result_t  res_q;

  assign in_beat = '{data_byte: in_data_byte, sof: in_start_of_frame};

  // Held beat moves to the result register when there is room
  assign advance = held_valid && has_space;

  trbp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  trbp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_beat    (in_beat),
    .advance    (advance),
    .held_valid (held_valid),
    .held_beat  (held_beat)
  );

  trbp_field_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .beat    (held_beat),
    .cfg     (cfg),
    .res     (res_comb)
  );

  trbp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .res_in    (res_comb),
    .has_space (has_space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_q)
  );

  assign out_field_code    = res_q.field_code;
  assign out_byte_position = res_q.byte_position;
  assign out_echoed_byte   = res_q.echoed_byte;
  assign out_number_value  = res_q.number_value;
  assign out_number_ready  = res_q.number_ready;
  assign out_parse_status  = res_q.parse_status;

endmodule

`default_nettype wire

/* rtl/trbp_checker.sv */
`default_nettype none

`include "transfer_record_byte_parser_assert.svh"

module trbp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [3:0]  out_field_code,
  input wire logic [15:0] out_byte_position,
  input wire logic [7:0]  out_echoed_byte,
  input wire logic [63:0] out_number_value,
  input wire logic        out_number_ready,
  input wire logic [1:0]  out_parse_status
);
  import trbp_pkg::*;

  logic is_numeric;
  logic ends_record;

  assign is_numeric = (out_field_code == FC_TIMESTAMP) || (out_field_code == FC_AMOUNT) ||
                      (out_field_code == FC_FEE) || (out_field_code == FC_ATT_LEN);
  assign ends_record = (out_field_code == FC_RECIPIENT) || (out_field_code == FC_ATT_LEN) ||
                       (out_field_code == FC_ATTACHMENT);

  // A stalled result beat holds
  `TRBP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_field_code) && $stable(out_byte_position) && $stable(out_echoed_byte) && $stable(out_number_value))

  // Non-numeric fields carry no number
  `TRBP_ASSERT_NOW(a_num_zero, out_valid && !is_numeric, out_number_value == 64'd0 && !out_number_ready)

  // Status only ever lands on recipient, attachment-length or attachment beats
  `TRBP_ASSERT_NOW(a_status_field, out_valid && out_parse_status != ST_BUSY, ends_record)

  // Ignored bytes sit at position zero and close nothing
  `TRBP_ASSERT_NOW(a_ignored, out_valid && out_field_code == FC_IGNORED, out_byte_position == 16'd0 && out_parse_status == ST_BUSY)

endmodule

bind transfer_record_byte_parser trbp_checker u_trbp_checker (.*);

`default_nettype wire

/* sim/tb_transfer_record_byte_parser.sv */
`default_nettype none

module tb_transfer_record_byte_parser;
  import trbp_pkg::*;

  localparam int LIMIT_CYCLES = 10_000_000;

  // Parser phases of the local predictor
  typedef enum logic [3:0] {
    PH_IDLE, PH_SENDER, PH_AFLAG, PH_AASSET, PH_FFLAG, PH_FASSET, PH_TS, PH_AMOUNT,
    PH_FEE, PH_RECIP, PH_ADDRESS, PH_ALIASHDR, PH_ALIAS, PH_ATTLEN, PH_ATTACH
  } phase_t;

  // Number byte styles for the frame builder
  localparam int NUM_RANDOM = 0;
  localparam int NUM_ONES   = 1;
  localparam int NUM_ZEROS  = 2;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_start_of_frame = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_field_code;
  logic [15:0] out_byte_position;
  logic [7:0]  out_echoed_byte;
  logic [63:0] out_number_value;
  logic        out_number_ready;
  logic [1:0]  out_parse_status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_ALIAS_MIN;
  logic [15:0] cfg_data = 16'd0;

  transfer_record_byte_parser uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_start_of_frame (in_start_of_frame),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_field_code    (out_field_code),
    .out_byte_position (out_byte_position),
    .out_echoed_byte   (out_echoed_byte),
    .out_number_value  (out_number_value),
    .out_number_ready  (out_number_ready),
    .out_parse_status  (out_parse_status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #2 clk = ~clk;

  // Predictor state and its copy of the limits
  phase_t      prs_phase = PH_IDLE;
  logic [15:0] prs_cnt = '0;
  logic [15:0] prs_len = '0;
  logic [63:0] prs_acc = '0;
  logic [15:0] lim_alias_min = ALIAS_MIN_RST;
  logic [15:0] lim_alias_max = ALIAS_MAX_RST;
  logic [15:0] lim_att_max = ATT_MAX_RST;

  result_t  tagged_q[$];
  in_beat_t frame_q[$];

  int err_cnt = 0;
  int beats_seen = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  int frames_cut = 0;
  int cfg_writes = 0;
  int n_accepted = 0;
  int n_bad_alias = 0;
  int n_att_long = 0;
  int burst_left = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void enter_phase(input phase_t p);
    prs_phase = p;
    prs_cnt = '0;
    prs_acc = '0;
  endfunction

  function automatic result_t tag_byte(input logic [7:0] b, input logic sof);
    result_t r;
    logic [15:0] cnt;
    phase_t nxt;
    r = '0;
    r.field_code = FC_IGNORED;
    r.echoed_byte = b;
    r.parse_status = ST_BUSY;
    cnt = prs_cnt;
    if (sof) begin
      // a frame start always wins, even mid-record
      r.field_code = FC_TYPE;
      prs_len = '0;
      enter_phase(PH_SENDER);
    end else begin
      case (prs_phase)
        PH_SENDER, PH_AASSET, PH_FASSET: begin
          if (prs_phase == PH_SENDER) begin
            r.field_code = FC_SENDER;
            nxt = PH_AFLAG;
          end else if (prs_phase == PH_AASSET) begin
            r.field_code = FC_AMT_ASSET;
            nxt = PH_FFLAG;
          end else begin
            r.field_code = FC_FEE_ASSET;
            nxt = PH_TS;
          end
          r.byte_position = cnt;
          prs_cnt = cnt + 16'd1;
          if (prs_cnt >= KEY_BYTES) enter_phase(nxt);
        end
        PH_AFLAG: begin
          r.field_code = FC_AMT_FLAG;
          if (b == 8'd1) enter_phase(PH_AASSET);
          else enter_phase(PH_FFLAG);
        end
        PH_FFLAG: begin
          r.field_code = FC_FEE_FLAG;
          if (b == 8'd1) enter_phase(PH_FASSET);
          else enter_phase(PH_TS);
        end
        PH_TS, PH_AMOUNT, PH_FEE: begin
          if (prs_phase == PH_TS) begin
            r.field_code = FC_TIMESTAMP;
            nxt = PH_AMOUNT;
          end else if (prs_phase == PH_AMOUNT) begin
            r.field_code = FC_AMOUNT;
            nxt = PH_FEE;
          end else begin
            r.field_code = FC_FEE;
            nxt = PH_RECIP;
          end
          r.byte_position = cnt;
          prs_acc = {prs_acc[55:0], b};
          r.number_value = prs_acc;
          prs_cnt = cnt + 16'd1;
          if (prs_cnt >= NUMBER_BYTES) begin
            r.number_ready = 1'b1;
            enter_phase(nxt);
          end
        end
        PH_RECIP: begin
          // first recipient byte picks address or alias
          r.field_code = FC_RECIPIENT;
          prs_len = '0;
          if (b == 8'd1) enter_phase(PH_ADDRESS);
          else enter_phase(PH_ALIASHDR);
          prs_cnt = 16'd1;
        end
        PH_ADDRESS: begin
          r.field_code = FC_RECIPIENT;
          r.byte_position = cnt;
          prs_cnt = cnt + 16'd1;
          if (prs_cnt >= RECIP_ADDR_BYTES) enter_phase(PH_ATTLEN);
        end
        PH_ALIASHDR: begin
          r.field_code = FC_RECIPIENT;
          r.byte_position = cnt;
          if (cnt >= 16'd2) prs_len = {prs_len[7:0], b};
          prs_cnt = cnt + 16'd1;
          if (prs_cnt >= ALIAS_HDR_BYTES) begin
            if (prs_len < lim_alias_min || prs_len > lim_alias_max) begin
              r.parse_status = ST_BAD_ALIAS;
              enter_phase(PH_IDLE);
            end else if (prs_len == 16'd0) begin
              enter_phase(PH_ATTLEN);
            end else begin
              enter_phase(PH_ALIAS);
            end
          end
        end
        PH_ALIAS: begin
          // positions carry on after the header and wrap at 16 bits
          r.field_code = FC_RECIPIENT;
          r.byte_position = cnt + ALIAS_HDR_BYTES;
          prs_cnt = cnt + 16'd1;
          if (prs_cnt >= prs_len) enter_phase(PH_ATTLEN);
        end
        PH_ATTLEN: begin
          r.field_code = FC_ATT_LEN;
          r.byte_position = cnt;
          prs_acc = {prs_acc[55:0], b};
          r.number_value = prs_acc;
          prs_cnt = cnt + 16'd1;
          if (prs_cnt >= ATT_LEN_BYTES) begin
            r.number_ready = 1'b1;
            prs_len = prs_acc[15:0];
            if (prs_len > lim_att_max) begin
              r.parse_status = ST_ATT_LONG;
              enter_phase(PH_IDLE);
            end else if (prs_len == 16'd0) begin
              r.parse_status = ST_ACCEPTED;
              enter_phase(PH_IDLE);
            end else begin
              enter_phase(PH_ATTACH);
            end
          end
        end
        PH_ATTACH: begin
          r.field_code = FC_ATTACHMENT;
          r.byte_position = cnt;
          prs_cnt = cnt + 16'd1;
          if (prs_cnt >= prs_len) begin
            r.parse_status = ST_ACCEPTED;
            enter_phase(PH_IDLE);
          end
        end
        default: prs_phase = PH_IDLE;
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver stall pattern: switches at random among four modes
  // ---------------------------------------------------------------------------
  int stall_mode = 0;
  int stall_left = 0;
  logic [7:0] stall_pat = 8'b1011_0010;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(50, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= stall_pat[stall_left[2:0]];
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    err_cnt++;
    if (err_cnt <= 40)
      $display("[%0t] beat %0d: %s is 0x%0h, expected 0x%0h", $time, beats_seen, what, got,
               want);
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      beats_seen++;
      if (tagged_q.size() == 0) begin
        report_mismatch("beat with nothing outstanding, field_code", out_field_code, '0);
      end else begin
        want = tagged_q.pop_front();
        if (out_field_code !== want.field_code)
          report_mismatch("field_code", out_field_code, want.field_code);
        if (out_byte_position !== want.byte_position)
          report_mismatch("byte_position", out_byte_position, want.byte_position);
        if (out_echoed_byte !== want.echoed_byte)
          report_mismatch("echoed_byte", out_echoed_byte, want.echoed_byte);
        if (out_number_value !== want.number_value)
          report_mismatch("number_value", out_number_value, want.number_value);
        if (out_number_ready !== want.number_ready)
          report_mismatch("number_ready", out_number_ready, want.number_ready);
        if (out_parse_status !== want.parse_status)
          report_mismatch("parse_status", out_parse_status, want.parse_status);
        case (want.parse_status)
          ST_ACCEPTED:  n_accepted++;
          ST_BAD_ALIAS: n_bad_alias++;
          ST_ATT_LONG:  n_att_long++;
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  // One input beat; the sender works in bursts with random gaps between them
  task automatic send_byte(input logic [7:0] b, input logic sof);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 30);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_start_of_frame <= sof;
    do @(posedge clk); while (!in_ready);
    tagged_q.push_back(tag_byte(b, sof));
    bytes_sent++;
  endtask

  // Stop sending and wait until every outstanding result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tagged_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ALIAS_MIN: lim_alias_min = val;
      CFG_ALIAS_MAX: lim_alias_max = val;
      CFG_ATT_MAX:   lim_att_max = val;
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk);
  endtask

  task automatic set_limits(input logic [15:0] amin, input logic [15:0] amax,
                            input logic [15:0] tmax);
    drain_results();
    write_reg(CFG_ALIAS_MIN, amin);
    write_reg(CFG_ALIAS_MAX, amax);
    write_reg(CFG_ATT_MAX, tmax);
  endtask

  // ---------------------------------------------------------------------------
  // Frame building
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] rnd_byte();
    return 8'($urandom);
  endfunction

  function automatic void put_byte(input logic [7:0] b, input logic sof);
    frame_q.push_back({b, sof});
  endfunction

  function automatic logic [7:0] not_one();
    logic [7:0] v;
    do v = rnd_byte(); while (v == 8'd1);
    return v;
  endfunction

  function automatic logic [7:0] num_byte(input int kind);
    if (kind == NUM_ONES) return 8'hFF;
    if (kind == NUM_ZEROS) return 8'h00;
    return rnd_byte();
  endfunction

  // Builds a whole record; bytes after a rejection are idle noise
  task automatic build_frame(input bit a_flag, input bit f_flag, input bit by_address,
                             input logic [15:0] alias_len, input logic [15:0] att_len,
                             input int kind);
    frame_q.delete();
    put_byte(rnd_byte(), 1'b1);
    repeat (32) put_byte(rnd_byte(), 1'b0);
    put_byte(a_flag ? 8'd1 : not_one(), 1'b0);
    if (a_flag) repeat (32) put_byte(rnd_byte(), 1'b0);
    put_byte(f_flag ? 8'd1 : not_one(), 1'b0);
    if (f_flag) repeat (32) put_byte(rnd_byte(), 1'b0);
    repeat (24) put_byte(num_byte(kind), 1'b0);
    if (by_address) begin
      put_byte(8'd1, 1'b0);
      repeat (25) put_byte(rnd_byte(), 1'b0);
    end else begin
      put_byte(not_one(), 1'b0);
      put_byte(rnd_byte(), 1'b0);
      put_byte(alias_len[15:8], 1'b0);
      put_byte(alias_len[7:0], 1'b0);
      if (alias_len < lim_alias_min || alias_len > lim_alias_max) begin
        repeat ($urandom_range(0, 3)) put_byte(rnd_byte(), 1'b0);
        return;
      end
      repeat (alias_len) put_byte(rnd_byte(), 1'b0);
    end
    put_byte(att_len[15:8], 1'b0);
    put_byte(att_len[7:0], 1'b0);
    if (att_len <= lim_att_max) repeat (att_len) put_byte(rnd_byte(), 1'b0);
    repeat ($urandom_range(0, 2)) put_byte(rnd_byte(), 1'b0);
  endtask

  // Sends the built frame, cut short after 'cut' bytes when cut is non-negative
  task automatic send_frame(input int cut);
    int n;
    n = frame_q.size();
    if (cut >= 0 && cut < n) begin
      n = cut;
      frames_cut++;
    end
    for (int k = 0; k < n; k++) send_byte(frame_q[k].data_byte, frame_q[k].sof);
    frames_sent++;
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 12)) send_byte(rnd_byte(), $urandom_range(0, 5) == 0);
  endtask

  task automatic random_frame();
    int amin;
    int amax;
    int tmax;
    int alen;
    int tlen;
    int kind;
    int cut;
    amin = lim_alias_min;
    amax = lim_alias_max;
    tmax = lim_att_max;
    // alias length: mostly within bounds, sometimes outside them
    if (amin <= amax && $urandom_range(0, 5) != 0)
      alen = amin + $urandom_range(0, (amax - amin > 24) ? 24 : amax - amin);
    else if (amax < 65535)
      alen = $urandom_range(amax + 1, 65535);
    else if (amin > 0)
      alen = $urandom_range(0, amin - 1);
    else
      alen = $urandom_range(0, 24);
    if ($urandom_range(0, 5) != 0 || tmax == 65535)
      tlen = $urandom_range(0, (tmax > 40) ? 40 : tmax);
    else
      tlen = $urandom_range(tmax + 1, 65535);
    case ($urandom_range(0, 9))
      0: kind = NUM_ONES;
      1: kind = NUM_ZEROS;
      default: kind = NUM_RANDOM;
    endcase
    build_frame(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 16'(alen), 16'(tlen), kind);
    cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, frame_q.size() - 1) : -1;
    send_frame(cut);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Bytes outside any record are tagged ignored
  task automatic test_idle_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(rnd_byte(), 1'b0);
  endtask

  // Address recipient with empty attachment, then both asset ids with an alias
  task automatic test_basic_records();
    build_frame(1'b0, 1'b0, 1'b1, 16'd0, 16'd0, NUM_ONES);
    send_frame(-1);
    build_frame(1'b1, 1'b1, 1'b0, ALIAS_MIN_RST, 16'd1, NUM_ZEROS);
    send_frame(-1);
  endtask

  // Alias lengths on the reset maximum and just past both reset limits, attachment just past its limit
  task automatic test_reset_limits();
    build_frame(1'b0, 1'b0, 1'b0, ALIAS_MAX_RST, 16'd2, NUM_RANDOM);
    send_frame(-1);
    build_frame(1'b0, 1'b0, 1'b0, ALIAS_MIN_RST - 16'd1, 16'd2, NUM_RANDOM);
    send_frame(-1);
    build_frame(1'b0, 1'b0, 1'b0, ALIAS_MAX_RST + 16'd1, 16'd2, NUM_RANDOM);
    send_frame(-1);
    build_frame(1'b0, 1'b0, 1'b1, 16'd0, ATT_MAX_RST + 16'd1, NUM_RANDOM);
    send_frame(-1);
  endtask

  // New frame start arriving in the middle of a record
  task automatic test_frame_restart();
    build_frame(1'b0, 1'b0, 1'b0, 16'd6, 16'd5, NUM_RANDOM);
    send_frame(1);
    send_frame(65);
    send_frame(-1);
  endtask

  // Sender holds off mid-record until everything has come back
  task automatic test_pause_mid_record();
    int half;
    build_frame(1'b0, 1'b0, 1'b0, 16'd8, 16'd4, NUM_RANDOM);
    half = frame_q.size() / 2;
    for (int k = 0; k < half; k++) send_byte(frame_q[k].data_byte, frame_q[k].sof);
    drain_results();
    for (int k = half; k < frame_q.size(); k++)
      send_byte(frame_q[k].data_byte, frame_q[k].sof);
    frames_sent++;
  endtask

  // Limits at their extremes: all zero, minimum above maximum, all ones
  task automatic test_limit_extremes();
    set_limits(16'd0, 16'd0, 16'd0);
    build_frame(1'b0, 1'b0, 1'b0, 16'd0, 16'd0, NUM_RANDOM);
    send_frame(-1);
    set_limits(16'd10, 16'd5, ATT_MAX_RST);
    build_frame(1'b0, 1'b0, 1'b0, 16'd7, 16'd1, NUM_RANDOM);
    send_frame(-1);
    set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF);
    build_frame(1'b0, 1'b0, 1'b0, 16'hFFFE, 16'd0, NUM_RANDOM);
    send_frame(-1);
  endtask

  // Records with random content under a few limit sets, some noise and cut frames
  task automatic test_random_records();
    int phase_start;
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: set_limits(16'd0, 16'd12, 16'd20);
        1: set_limits(16'($urandom_range(0, 6)), 16'($urandom_range(0, 40)),
                      16'($urandom_range(0, 60)));
        default: set_limits(16'd5, 16'hFFFF, 16'd0);
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 40) begin
        if ($urandom_range(0, 6) == 0) send_noise();
        else random_frame();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_bytes();
    test_basic_records();
    test_reset_limits();
    test_frame_restart();
    test_pause_mid_record();
    test_limit_extremes();
    test_random_records();
    drain_results();
    repeat (8) @(posedge clk);
    $display("Run: %0d bytes in %0d frames (%0d cut short), %0d register writes",
             bytes_sent, frames_sent, frames_cut, cfg_writes);
    $display("Outcomes: %0d records accepted, %0d alias rejections, %0d oversize attachments",
             n_accepted, n_bad_alias, n_att_long);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(LIMIT_CYCLES * 4);
    $display("Timed out with %0d results outstanding", tagged_q.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
